// ===== design/tgc_pkg.sv =====
package tgc_pkg;

  localparam int TRIG_TABLE_DEPTH = 256;
  localparam int TRIG_IDX_W       = $clog2(TRIG_TABLE_DEPTH);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_DIRECTION_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PHASE_STEP     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HALF_STRIDE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LIFT_HEIGHT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_GROUND_Y       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CENTRE_X       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_STAND_Y        = 3'd6;

  localparam logic [1:0] MODE_BACKWARD = 2'd0;
  localparam logic [1:0] MODE_FORWARD  = 2'd1;

  typedef struct packed {
    logic [1:0]         direction_mode;
    logic [15:0]        phase_step;
    logic [14:0]        half_stride;
    logic [14:0]        lift_height;
    logic signed [15:0] ground_y;
    logic signed [15:0] centre_x;
    logic signed [15:0] stand_y;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] front_left_x;
    logic signed [15:0] front_left_y;
    logic signed [15:0] front_right_x;
    logic signed [15:0] front_right_y;
    logic signed [15:0] rear_right_x;
    logic signed [15:0] rear_right_y;
    logic signed [15:0] rear_left_x;
    logic signed [15:0] rear_left_y;
    logic               cycle_wrap;
  } result_t;

  typedef logic signed [15:0] trig_tab_t [TRIG_TABLE_DEPTH];

  // Q1.14 sine, angle in 1/65536 turn, odd polynomial per quadrant
  function automatic logic signed [15:0] poly_sine(input logic [15:0] ang);
    logic [1:0]         q;
    logic [31:0]        r;
    logic [31:0]        z;
    logic [31:0]        z2;
    logic [31:0]        t;
    logic [31:0]        y;
    logic signed [15:0] ys;
    q  = ang[15:14];
    r  = {18'd0, ang[13:0]};
    z  = q[0] ? (32'd16384 - r) : r;
    z2 = (z * z) >> 14;
    t  = 32'd10512 - ((z2 * 32'd1160) >> 14);
    t  = 32'd25736 - ((z2 * t) >> 14);
    y  = (z * t) >> 14;
    ys = signed'(y[15:0]);
    return q[1] ? -ys : ys;
  endfunction

  function automatic trig_tab_t build_trig_table(input logic cosine);
    trig_tab_t   tab;
    int unsigned ang;
    for (int k = 0; k < TRIG_TABLE_DEPTH; k++) begin
      ang = ((k * 65536) / TRIG_TABLE_DEPTH) & 32'hFFFF;
      if (cosine) begin
        ang = (ang + 32'd16384) & 32'hFFFF;
      end
      tab[k] = poly_sine(ang[15:0]);
    end
    return tab;
  endfunction

  localparam trig_tab_t SINE_TABLE   = build_trig_table(1'b0);
  localparam trig_tab_t COSINE_TABLE = build_trig_table(1'b1);

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

// ===== design/tgc_cfg_regs.sv =====
module tgc_cfg_regs
  import tgc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction_mode <= MODE_FORWARD;
      cfg.phase_step     <= 16'd2621;
      cfg.half_stride    <= 15'd800;
      cfg.lift_height    <= 15'd560;
      cfg.ground_y       <= -16'sd2400;
      cfg.centre_x       <= 16'sd0;
      cfg.stand_y        <= -16'sd2400;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_IDX_DIRECTION_MODE: cfg.direction_mode <= wr_data[1:0];
        CFG_IDX_PHASE_STEP:     cfg.phase_step     <= wr_data;
        CFG_IDX_HALF_STRIDE:    cfg.half_stride    <= wr_data[14:0];
        CFG_IDX_LIFT_HEIGHT:    cfg.lift_height    <= wr_data[14:0];
        CFG_IDX_GROUND_Y:       cfg.ground_y       <= signed'(wr_data);
        CFG_IDX_CENTRE_X:       cfg.centre_x       <= signed'(wr_data);
        CFG_IDX_STAND_Y:        cfg.stand_y        <= signed'(wr_data);
        default: ;
      endcase
    end
  end

endmodule

// ===== design/tgc_datapath.sv =====
module tgc_datapath
  import tgc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_phase,
  input  logic        in_wrap,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_result
);

  localparam int IDX_PROD_W = 17 + $clog2(TRIG_TABLE_DEPTH + 1);
  localparam int IDX_FULL_W = IDX_PROD_W - 16;

  // stage 1: table lookup and the two products
  logic                  first;
  logic [16:0]           u;
  logic [IDX_PROD_W-1:0] idx_prod;
  logic [IDX_FULL_W-1:0] idx_full;
  logic [TRIG_IDX_W-1:0] idx;
  logic signed [15:0]    sn;
  logic signed [15:0]    cs;
  logic signed [16:0]    cs_off;

  logic                  s1_valid;
  logic signed [30:0]    s1_sn_prod;
  logic [30:0]           s1_lift_prod;
  logic [16:0]           s1_u;
  logic                  s1_first;
  logic                  s1_wrap;

  // stage 2: cycloid fraction and lift y
  logic [30:0]           sn_rnd;
  logic signed [14:0]    sn_q16;
  logic signed [17:0]    f_raw;
  logic [16:0]           f_clamped;
  logic [30:0]           lift_rnd;
  logic [15:0]           lift;

  logic                  s2_valid;
  logic [16:0]           s2_f;
  logic signed [15:0]    s2_ly;
  logic                  s2_first;
  logic                  s2_wrap;

  // output stage
  logic [33:0]           d_prod;
  logic [16:0]           d;
  logic signed [15:0]    swing;
  logic signed [15:0]    stance;
  logic                  a_swing;
  logic                  stand;
  logic signed [15:0]    xa;
  logic signed [15:0]    xb;
  result_t               result_next;

  logic                  s1_ready;
  logic                  s2_ready;
  logic                  out_load;

  assign out_load = !out_valid || out_ready;
  assign s2_ready = !s2_valid || out_load;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    first    = (in_phase <= 16'd32768);
    u        = first ? {in_phase, 1'b0} : {in_phase - 16'd32768, 1'b0};
    idx_prod = IDX_PROD_W'(u) * IDX_PROD_W'(TRIG_TABLE_DEPTH);
    idx_full = idx_prod[IDX_PROD_W-1:16];
    // u of a full half cycle wraps back to entry zero
    if (idx_full >= IDX_FULL_W'(TRIG_TABLE_DEPTH)) begin
      idx = '0;
    end else begin
      idx = idx_full[TRIG_IDX_W-1:0];
    end
    sn     = SINE_TABLE[idx];
    cs     = COSINE_TABLE[idx];
    cs_off = 17'sd16384 - 17'(cs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_sn_prod   <= 31'(sn) * 31'sd41722;
      s1_lift_prod <= 31'(cfg.lift_height) * 31'(cs_off[15:0]);
      s1_u         <= u;
      s1_first     <= first;
      s1_wrap      <= in_wrap;
    end
  end

  always_comb begin
    // sin/(2*pi) in Q0.16, half rounded upward
    sn_rnd = s1_sn_prod + 31'sd32768;
    sn_q16 = signed'(sn_rnd[30:16]);
    f_raw  = signed'({1'b0, s1_u}) - 18'(sn_q16);
    if (f_raw < 18'sd0) begin
      f_clamped = 17'd0;
    end else if (f_raw > 18'sd65536) begin
      f_clamped = 17'd65536;
    end else begin
      f_clamped = f_raw[16:0];
    end
    lift_rnd = s1_lift_prod + 31'd16384;
    lift     = lift_rnd[30:15];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_f     <= f_clamped;
      s2_ly    <= sat16(19'(cfg.ground_y) + signed'({3'b0, lift}));
      s2_first <= s1_first;
      s2_wrap  <= s1_wrap;
    end
  end

  always_comb begin
    d_prod = 34'({cfg.half_stride, 1'b0}) * 34'(s2_f) + 34'd32768;
    d      = d_prod[32:16];
    swing  = sat16(19'(cfg.centre_x) - signed'({4'b0, cfg.half_stride})
                   + signed'({2'b0, d}));
    stance = sat16(19'(cfg.centre_x) + signed'({4'b0, cfg.half_stride})
                   - signed'({2'b0, d}));
    a_swing = s2_first;
    stand   = 1'b0;
    case (cfg.direction_mode)
      MODE_FORWARD:  a_swing = s2_first;
      MODE_BACKWARD: a_swing = !s2_first;
      default:       stand = 1'b1;
    endcase
    xa = a_swing ? swing : stance;
    xb = a_swing ? stance : swing;
    if (stand) begin
      result_next.front_left_x  = cfg.centre_x;
      result_next.front_left_y  = cfg.stand_y;
      result_next.front_right_x = cfg.centre_x;
      result_next.front_right_y = cfg.stand_y;
      result_next.rear_right_x  = cfg.centre_x;
      result_next.rear_right_y  = cfg.stand_y;
      result_next.rear_left_x   = cfg.centre_x;
      result_next.rear_left_y   = cfg.stand_y;
    end else begin
      // diagonal pairs: front left with rear right lift in the first half
      result_next.front_left_x  = xa;
      result_next.front_left_y  = s2_first ? s2_ly : cfg.ground_y;
      result_next.front_right_x = xb;
      result_next.front_right_y = s2_first ? cfg.ground_y : s2_ly;
      result_next.rear_right_x  = xb;
      result_next.rear_right_y  = s2_first ? s2_ly : cfg.ground_y;
      result_next.rear_left_x   = xa;
      result_next.rear_left_y   = s2_first ? cfg.ground_y : s2_ly;
    end
    result_next.cycle_wrap = s2_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s2_valid) begin
      out_result <= result_next;
    end
  end

endmodule

// ===== design/trot_gait_cycloid_trajectory.sv =====
// Trot gait cycloid foot trajectory, four legs, Q11.4 mm targets.
// Throughput: one item per cycle while m_tready does not stall the output; set by the
// three-register pipeline (table/product, fraction/lift, stride product/select)
// and a single-add phase accumulator.
// Reset (rst, synchronous): phase cleared, pipeline emptied, registers to their defaults.
module trot_gait_cycloid_trajectory
  import tgc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [0] tick, [7:1] zero
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [135:0]           m_tdata,   // front_left_x, front_left_y, front_right_x,
                                            // front_right_y, rear_right_x, rear_right_y,
                                            // rear_left_x, rear_left_y (16 each),
                                            // [128] cycle_wrap, [135:129] zero
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t        cfg;
  result_t     result;
  logic [15:0] gait_phase;
  logic [16:0] phase_sum;
  logic        accept;
  logic        wrap;

  assign cfg_ready = 1'b1;

  tgc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign accept    = s_tvalid && s_tready;
  assign phase_sum = {1'b0, gait_phase} + {1'b0, cfg.phase_step};
  // phase restarts at zero on reaching one cycle, remainder dropped
  assign wrap      = s_tdata[0] && phase_sum[16];

  always_ff @(posedge clk) begin
    if (rst) begin
      gait_phase <= 16'd0;
    end else if (accept && s_tdata[0]) begin
      gait_phase <= phase_sum[16] ? 16'd0 : phase_sum[15:0];
    end
  end

  tgc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_phase   (gait_phase),
    .in_wrap    (wrap),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = {7'd0, result.cycle_wrap,
                    result.rear_left_y, result.rear_left_x,
                    result.rear_right_y, result.rear_right_x,
                    result.front_right_y, result.front_right_x,
                    result.front_left_y, result.front_left_x};

`ifndef SYNTH
  a_idle_tick_holds_phase: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tdata[0]) |=> (gait_phase == $past(gait_phase)))
    else $error("idle tick moved the gait phase");

  a_phase_moves_on_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(gait_phase))
    else $error("gait phase changed without an accepted item");

  a_stall_only_from_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while output side was free");

  a_stand_mode_targets: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && cfg.direction_mode[1]) |->
      (m_tdata[15:0] == cfg.centre_x && m_tdata[127:112] == cfg.stand_y))
    else $error("stand mode item not at centre x and stand y");
`endif

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import tgc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] MODE_STAND  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // same layout as m_tdata[128:0]: coord[0] is front_left_x in the low bits
  typedef struct packed {
    logic            wrap;
    logic [7:0][15:0] coord;
  } targets_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;   // [0] tick, [7:1] zero
  logic                   m_tvalid;
  logic                   m_tready;
  logic [135:0]           m_tdata;   // eight coordinates (16 each), [128] cycle_wrap
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cfg_t        gait_cfg;
  logic [15:0] gait_phase;
  logic [16:0] phase_sum;
  targets_t    want;
  targets_t    got;
  targets_t    expected_targets[$];
  logic        pending_ticks[$];
  logic        tick_taken = 1'b0;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          error_count = 0;
  int          cycle_count = 0;

  trot_gait_cycloid_trajectory u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Q1.14 sine, angle in 1/65536 turn
  function automatic longint q14_sine(input longint turn);
    longint quad, rem, z, z2, t, mag;
    quad = (turn >> 14) & 3;
    rem  = turn & 16383;
    z    = (quad & 1) ? 16384 - rem : rem;
    z2   = (z * z) >> 14;
    t    = 10512 - ((z2 * 1160) >> 14);
    t    = 25736 - ((z2 * t) >> 14);
    mag  = (z * t) >> 14;
    return (quad & 2) ? -mag : mag;
  endfunction

  function automatic logic [15:0] clip16(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic targets_t foot_targets(input logic [15:0] ph);
    targets_t    tg;
    logic        first_half;
    logic        a_swing;
    longint      u, idx, ang, sn, cs, frac, s, cx, gy, d;
    logic [15:0] swing_x, stance_x, lift_y, xa, xb;
    first_half = (ph <= 16'd32768);
    u   = first_half ? 2 * longint'(ph) : 2 * (longint'(ph) - 32768);
    idx = (u * TRIG_TABLE_DEPTH) >> 16;
    // u of exactly one wraps to the first entry
    if (idx >= TRIG_TABLE_DEPTH) idx = 0;
    ang  = ((idx * 65536) / TRIG_TABLE_DEPTH) & 65535;
    sn   = q14_sine(ang);
    cs   = q14_sine((ang + 16384) & 65535);
    frac = u - ((sn * 41722 + 32768) >>> 16);
    if (frac < 0) frac = 0;
    if (frac > 65536) frac = 65536;
    s  = longint'(gait_cfg.half_stride);
    cx = longint'($signed(gait_cfg.centre_x));
    gy = longint'($signed(gait_cfg.ground_y));
    d  = (2 * s * frac + 32768) >> 16;
    swing_x  = clip16(cx - s + d);
    stance_x = clip16(cx + s - d);
    lift_y   = clip16(gy + ((longint'(gait_cfg.lift_height) * (16384 - cs) + 16384) >> 15));
    tg = '0;
    if (gait_cfg.direction_mode == MODE_FORWARD || gait_cfg.direction_mode == MODE_BACKWARD) begin
      a_swing = (gait_cfg.direction_mode == MODE_FORWARD) ? first_half : !first_half;
      xa = a_swing ? swing_x : stance_x;
      xb = a_swing ? stance_x : swing_x;
      tg.coord[0] = xa;
      tg.coord[2] = xb;
      tg.coord[4] = xb;
      tg.coord[6] = xa;
      tg.coord[1] = first_half ? lift_y : gait_cfg.ground_y;
      tg.coord[3] = first_half ? gait_cfg.ground_y : lift_y;
      tg.coord[5] = tg.coord[1];
      tg.coord[7] = tg.coord[3];
    end else begin
      for (int k = 0; k < 4; k++) begin
        tg.coord[2*k]   = gait_cfg.centre_x;
        tg.coord[2*k+1] = gait_cfg.stand_y;
      end
    end
    return tg;
  endfunction

  function automatic string coord_name(input int k);
    case (k)
      0: return "front_left_x";
      1: return "front_left_y";
      2: return "front_right_x";
      3: return "front_right_y";
      4: return "rear_right_x";
      5: return "rear_right_y";
      6: return "rear_left_x";
      default: return "rear_left_y";
    endcase
  endfunction

  // extremes, full range, or a moderate band around zero
  function automatic int rand_coord(input int lo, input int hi);
    int a, b;
    a = (lo > -3000) ? lo : -3000;
    b = (hi < 3000) ? hi : 3000;
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      2, 3: return int'($urandom_range(0, hi - lo)) + lo;
      default: return int'($urandom_range(0, b - a)) + a;
    endcase
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || tick_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pending_ticks[0]};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // predictor and checker
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      tick_taken = !rst && s_tvalid && s_tready;
      if (tick_taken) begin
        want = foot_targets(gait_phase);
        if (s_tdata[0]) begin
          phase_sum = {1'b0, gait_phase} + {1'b0, gait_cfg.phase_step};
          // restart at zero, remainder dropped
          if (phase_sum[16]) begin
            gait_phase = '0;
            want.wrap  = 1'b1;
          end else begin
            gait_phase = phase_sum[15:0];
          end
        end
        expected_targets.push_back(want);
        void'(pending_ticks.pop_front());
      end
      if (!rst && m_tvalid && m_tready) begin
        got = m_tdata[128:0];
        if (expected_targets.size() == 0) begin
          $display("%0t unexpected item: expected none, got %h", $time, m_tdata);
          error_count++;
        end else begin
          want = expected_targets.pop_front();
          for (int k = 0; k < 8; k++) begin
            if (got.coord[k] !== want.coord[k]) begin
              $display("%0t %s: expected %0d, got %0d", $time, coord_name(k),
                       $signed(want.coord[k]), $signed(got.coord[k]));
              error_count++;
            end
          end
          if (got.wrap !== want.wrap) begin
            $display("%0t cycle_wrap: expected %0b, got %0b", $time, want.wrap, got.wrap);
            error_count++;
          end
        end
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk); while (pending_ticks.size() != 0 || expected_targets.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IDX_DIRECTION_MODE: gait_cfg.direction_mode = val[1:0];
      CFG_IDX_PHASE_STEP:     gait_cfg.phase_step     = val[15:0];
      CFG_IDX_HALF_STRIDE:    gait_cfg.half_stride    = val[14:0];
      CFG_IDX_LIFT_HEIGHT:    gait_cfg.lift_height    = val[14:0];
      CFG_IDX_GROUND_Y:       gait_cfg.ground_y       = val[15:0];
      CFG_IDX_CENTRE_X:       gait_cfg.centre_x       = val[15:0];
      CFG_IDX_STAND_Y:        gait_cfg.stand_y        = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_ticks(input int n, input int one_pct);
    @(posedge clk);
    repeat (n) pending_ticks.push_back($urandom_range(0, 99) < one_pct);
  endtask

  task automatic random_gait_phase(input int n_ticks);
    int m;
    m = $urandom_range(0, 6);
    write_reg(CFG_IDX_DIRECTION_MODE,
              (m < 3) ? MODE_FORWARD : (m < 5) ? MODE_BACKWARD : MODE_STAND);
    case ($urandom_range(0, 7))
      0: write_reg(CFG_IDX_PHASE_STEP, 1);
      1: write_reg(CFG_IDX_PHASE_STEP, 65535);
      2, 3: write_reg(CFG_IDX_PHASE_STEP, $urandom_range(1, 65535));
      default: write_reg(CFG_IDX_PHASE_STEP, $urandom_range(200, 6000));
    endcase
    write_reg(CFG_IDX_HALF_STRIDE, rand_coord(0, 32767));
    write_reg(CFG_IDX_LIFT_HEIGHT, rand_coord(0, 32767));
    write_reg(CFG_IDX_GROUND_Y, rand_coord(-32768, 32767));
    write_reg(CFG_IDX_CENTRE_X, rand_coord(-32768, 32767));
    write_reg(CFG_IDX_STAND_Y, rand_coord(-32768, 32767));
    send_ticks(n_ticks, 85);
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    gait_cfg.direction_mode = MODE_FORWARD;
    gait_cfg.phase_step     = 16'd2621;
    gait_cfg.half_stride    = 15'd800;
    gait_cfg.lift_height    = 15'd560;
    gait_cfg.ground_y       = -16'sd2400;
    gait_cfg.centre_x       = 16'sd0;
    gait_cfg.stand_y        = -16'sd2400;
    gait_phase    = '0;
    send_idle_pct = 22;
    recv_idle_pct = 48;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults, idle ticks around stepping ones
    send_ticks(1, 0);
    send_ticks(2, 100);
    send_ticks(1, 0);
    // wrap to zero, then quarter steps so a half ends exactly at one half
    write_reg(CFG_IDX_PHASE_STEP, 65535);
    send_ticks(1, 100);
    write_reg(CFG_IDX_PHASE_STEP, 16384);
    send_ticks(5, 100);
    write_reg(CFG_IDX_PHASE_STEP, 65535);
    send_ticks(2, 100);
    // saturation at both ends, backward pairing
    write_reg(CFG_IDX_DIRECTION_MODE, MODE_BACKWARD);
    write_reg(CFG_IDX_HALF_STRIDE, 32767);
    write_reg(CFG_IDX_LIFT_HEIGHT, 32767);
    write_reg(CFG_IDX_GROUND_Y, 32767);
    write_reg(CFG_IDX_CENTRE_X, 32767);
    write_reg(CFG_IDX_PHASE_STEP, 12000);
    send_ticks(4, 100);
    write_reg(CFG_IDX_CENTRE_X, -32768);
    write_reg(CFG_IDX_GROUND_Y, -32768);
    send_ticks(3, 100);
    // stand still, and the unused mode code acting as stand
    write_reg(CFG_IDX_DIRECTION_MODE, MODE_STAND);
    write_reg(CFG_IDX_STAND_Y, -32768);
    send_ticks(2, 100);
    write_reg(CFG_IDX_DIRECTION_MODE, MODE_UNUSED);
    write_reg(CFG_IDX_STAND_Y, 32767);
    send_ticks(1, 100);
    // zero step holds the phase
    write_reg(CFG_IDX_DIRECTION_MODE, MODE_FORWARD);
    write_reg(CFG_IDX_PHASE_STEP, 0);
    send_ticks(2, 100);

    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        send_idle_pct = 48;
        recv_idle_pct = 22;
      end else if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_gait_phase(88);
    end

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tgc_pkg.sv
design/tgc_cfg_regs.sv
design/tgc_datapath.sv
design/trot_gait_cycloid_trajectory.sv
verif/testbench.sv
